// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only
`define VRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge, reset included
`define VRT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/vrt_pkg.sv =====
// ---------------------------------------------------------------------------
// vrt_pkg
// Shared widths, constants and control types of the voxel ray traversal.
// ---------------------------------------------------------------------------
package vrt_pkg;

    // Default grid size per axis
    localparam int unsigned GRID_X_DEF = 32;
    localparam int unsigned GRID_Y_DEF = 32;
    localparam int unsigned GRID_Z_DEF = 32;

    // Field widths
    localparam int POS_W   = 24;   // Q8.16 position
    localparam int DIR_W   = 18;   // Q2.16 heading
    localparam int MAG_W   = 18;   // heading magnitude
    localparam int CELL_W  = 8;
    localparam int BLK_W   = 8;
    localparam int DIST_W  = 26;   // Q10.16 distance
    localparam int UNIT_W  = 33;   // 2^32 / magnitude
    localparam int FRAC_W  = 17;
    localparam int LEN_W   = 51;   // exact walk lengths
    localparam int MT_W    = 41;   // clamped |t| for the surface product
    localparam int MT_LO_W = 24;
    localparam int ACC_W   = 59;
    localparam int Q_W     = ACC_W - 16;
    localparam int DIV_STEPS = 33;

    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 136;

    localparam logic [LEN_W-1:0]  LEN_NONE = LEN_W'(1) << 50;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [DIST_W-1:0] Q_SAT    = DIST_W'(1) << 25;

    // Item kinds on tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    // Axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // Commands from the controller
    typedef struct packed {
        logic       clr_wr;
        logic       vox_wr;
        logic       load;
        logic       div_start;
        logic       unit_wr;
        logic       len_wr;
        logic       rd;
        logic       step;
        logic       mul_lo;
        logic       mul_hi;
        logic       surf_wr;
        logic       out_wr;
        logic [1:0] ax;
    } cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic border;
        logic hit;
        logic exit_walk;
    } sts_t;

endpackage

// ===== rtl/vrt_ram.sv =====
// ---------------------------------------------------------------------------
// vrt_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module vrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/vrt_div.sv =====
// ---------------------------------------------------------------------------
// vrt_div
// Restoring divider for 2^32 / magnitude, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module vrt_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [vrt_pkg::MAG_W-1:0]   divisor,
    output logic                        done,
    output logic [vrt_pkg::UNIT_W-1:0]  quot
);

    localparam int CNT_W = $clog2(vrt_pkg::DIV_STEPS);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [vrt_pkg::MAG_W-1:0]   rem_reg, rem_next;
    logic [vrt_pkg::UNIT_W-1:0]  quot_reg, quot_next;
    logic [vrt_pkg::MAG_W:0]     shifted;
    logic [vrt_pkg::MAG_W:0]     trial;
    logic                        ge;

    // Dividend is a single one at bit 32, so only the first bit shifted in is set
    always_comb begin
        shifted = {rem_reg, (cnt_reg == '0)};
        trial   = shifted - {1'b0, divisor};
        ge      = shifted >= {1'b0, divisor};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? trial[vrt_pkg::MAG_W-1:0] : shifted[vrt_pkg::MAG_W-1:0];
            quot_next = {quot_reg[vrt_pkg::UNIT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(vrt_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/vrt_dpath.sv =====
// ---------------------------------------------------------------------------
// vrt_dpath
// Datapath: voxel store, ray setup, DDA step, surface point and result register.
// ---------------------------------------------------------------------------
module vrt_dpath #(
    parameter int unsigned GRID_X = vrt_pkg::GRID_X_DEF,
    parameter int unsigned GRID_Y = vrt_pkg::GRID_Y_DEF,
    parameter int unsigned GRID_Z = vrt_pkg::GRID_Z_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  vrt_pkg::cmd_t                     cmd,
    output vrt_pkg::sts_t                     sts,
    input  logic [vrt_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic [vrt_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int PLANE = GRID_X * GRID_Y;
    localparam int PAD_W = vrt_pkg::OUT_TDATA_W - (vrt_pkg::DIST_W + vrt_pkg::BLK_W
                           + 3 * vrt_pkg::CELL_W + 3 * vrt_pkg::POS_W);
    localparam int GRID [3] = '{GRID_X, GRID_Y, GRID_Z};

    // Input fields
    logic [vrt_pkg::CELL_W-1:0] vx, vy, vz;
    logic [vrt_pkg::BLK_W-1:0]  bv;
    logic [vrt_pkg::POS_W-1:0]  in_pos [3];
    logic [vrt_pkg::DIR_W-1:0]  in_dir [3];

    assign vx = s_tdata[7:0];
    assign vy = s_tdata[15:8];
    assign vz = s_tdata[23:16];
    assign bv = s_tdata[31:24];
    assign in_pos[0] = s_tdata[55:32];
    assign in_pos[1] = s_tdata[79:56];
    assign in_pos[2] = s_tdata[103:80];
    assign in_dir[0] = s_tdata[121:104];
    assign in_dir[1] = s_tdata[139:122];
    assign in_dir[2] = s_tdata[157:140];

    // Ray state
    logic [vrt_pkg::POS_W-1:0]  pos_reg  [3];
    logic [vrt_pkg::DIR_W-1:0]  dir_reg  [3];
    logic [vrt_pkg::CELL_W-1:0] cell_reg [3];
    logic [vrt_pkg::UNIT_W-1:0] unit_reg [3];
    logic [vrt_pkg::LEN_W-1:0]  len_reg  [3];
    logic [vrt_pkg::POS_W-1:0]  surf_reg [3];
    logic [vrt_pkg::LEN_W-1:0]  d_reg;
    logic [vrt_pkg::MT_W-1:0]   mt_reg;
    logic                       tneg_reg;
    logic [vrt_pkg::BLK_W-1:0]  blk_reg;
    logic [vrt_pkg::ACC_W-1:0]  acc_reg;
    logic [vrt_pkg::ACC_W-1:0]  hi_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic [vrt_pkg::OUT_TDATA_W-1:0] out_reg;

    // ---- voxel store ----
    logic [AW-1:0]             waddr, raddr, vidx;
    logic [vrt_pkg::BLK_W-1:0] wdata, rdata;
    logic                      we, in_grid;

    assign vidx  = AW'(vx) + AW'(GRID_X) * AW'(vy) + AW'(PLANE) * AW'(vz);
    assign raddr = AW'(cell_reg[0]) + AW'(GRID_X) * AW'(cell_reg[1])
                 + AW'(PLANE) * AW'(cell_reg[2]);
    assign in_grid = (vx < vrt_pkg::CELL_W'(GRID_X)) && (vy < vrt_pkg::CELL_W'(GRID_Y))
                  && (vz < vrt_pkg::CELL_W'(GRID_Z));
    assign we    = cmd.clr_wr || (cmd.vox_wr && in_grid);
    assign waddr = cmd.clr_wr ? clr_addr_reg : vidx;
    assign wdata = cmd.clr_wr ? '0 : bv;

    vrt_ram #(
        .WIDTH (vrt_pkg::BLK_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (raddr),
        .rdata (rdata)
    );

    // ---- reciprocal unit ----
    logic [vrt_pkg::DIR_W-1:0]  dir_ax;
    logic [vrt_pkg::POS_W-1:0]  pos_ax;
    logic [vrt_pkg::MAG_W-1:0]  mag_ax;
    logic [vrt_pkg::UNIT_W-1:0] quot;
    logic                       div_done;

    assign dir_ax = dir_reg[cmd.ax];
    assign pos_ax = pos_reg[cmd.ax];
    assign mag_ax = dir_ax[vrt_pkg::DIR_W-1] ? (~dir_ax + 1'b1) : dir_ax;

    vrt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .divisor (mag_ax),
        .done    (div_done),
        .quot    (quot)
    );

    // First boundary length: frac to the next boundary times unit
    logic [vrt_pkg::FRAC_W-1:0]                 frac;
    logic [vrt_pkg::FRAC_W+vrt_pkg::UNIT_W-1:0] len_prod;
    logic                                       dir_pos, dir_zero;

    assign dir_zero = (dir_ax == '0);
    assign dir_pos  = !dir_ax[vrt_pkg::DIR_W-1] && !dir_zero;
    assign frac     = dir_pos ? (vrt_pkg::FRAC_W'(1) << 16) - vrt_pkg::FRAC_W'(pos_ax[15:0])
                              : vrt_pkg::FRAC_W'(pos_ax[15:0]);
    assign len_prod = frac * unit_reg[cmd.ax];

    // ---- DDA step ----
    logic [1:0]                 sel;
    logic [vrt_pkg::CELL_W-1:0] cell_new;
    logic [vrt_pkg::LEN_W-1:0]  d_new;
    logic                       sel_pos, new_border, border;

    always_comb begin
        if (len_reg[0] < len_reg[1] && len_reg[0] < len_reg[2]) begin
            sel = vrt_pkg::AX_X;
        end else if (len_reg[1] < len_reg[2]) begin
            sel = vrt_pkg::AX_Y;
        end else begin
            sel = vrt_pkg::AX_Z;
        end
        sel_pos    = !dir_reg[sel][vrt_pkg::DIR_W-1] && (dir_reg[sel] != '0);
        cell_new   = sel_pos ? cell_reg[sel] + 1'b1 : cell_reg[sel] - 1'b1;
        d_new      = len_reg[sel];
        new_border = (cell_new == '0) || (cell_new >= vrt_pkg::CELL_W'(GRID[sel]));
        border     = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (cell_reg[a] == '0 || cell_reg[a] >= vrt_pkg::CELL_W'(GRID[a])) begin
                border = 1'b1;
            end
        end
    end

    // |t| clamped to the product width
    function automatic logic [vrt_pkg::MT_W-1:0] sat_mt(input logic [vrt_pkg::LEN_W-1:0] v);
        if (v[vrt_pkg::LEN_W-1:vrt_pkg::MT_W] != '0) begin
            return '1;
        end
        return v[vrt_pkg::MT_W-1:0];
    endfunction

    // ---- surface point ----
    logic [vrt_pkg::ACC_W-1:0]  sum;
    logic [vrt_pkg::Q_W-1:0]    q;
    logic [vrt_pkg::DIST_W-1:0] qc;
    logic [vrt_pkg::POS_W+3:0]  sres;
    logic [vrt_pkg::POS_W-1:0]  surf_val;
    logic                       neg;

    always_comb begin
        sum  = acc_reg + (hi_reg << 24);
        q    = sum[vrt_pkg::ACC_W-1:16];
        qc   = (q > vrt_pkg::Q_W'(vrt_pkg::Q_SAT)) ? vrt_pkg::Q_SAT : q[vrt_pkg::DIST_W-1:0];
        neg  = tneg_reg ^ dir_ax[vrt_pkg::DIR_W-1];
        sres = neg ? {4'b0, pos_ax} - {2'b0, qc} : {4'b0, pos_ax} + {2'b0, qc};
        if (sres[vrt_pkg::POS_W+3]) begin
            surf_val = '0;
        end else if (sres[vrt_pkg::POS_W+2:vrt_pkg::POS_W] != '0) begin
            surf_val = '1;
        end else begin
            surf_val = sres[vrt_pkg::POS_W-1:0];
        end
    end

    // Saturated distance
    logic [vrt_pkg::DIST_W-1:0] dist_sat;
    assign dist_sat = (d_reg > vrt_pkg::LEN_W'(vrt_pkg::DIST_MAX)) ? vrt_pkg::DIST_MAX
                                                                  : d_reg[vrt_pkg::DIST_W-1:0];

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end

        // Load a cast item
        if (cmd.load) begin
            for (int a = 0; a < 3; a++) begin
                pos_reg[a]  <= in_pos[a];
                dir_reg[a]  <= in_dir[a];
                cell_reg[a] <= in_pos[a][vrt_pkg::POS_W-1:16];
            end
            d_reg    <= '0;
            mt_reg   <= '0;
            tneg_reg <= 1'b0;
            blk_reg  <= '0;
        end

        // Setup per axis
        if (cmd.unit_wr) begin
            unit_reg[cmd.ax] <= dir_zero ? '0 : quot;
        end
        if (cmd.len_wr) begin
            len_reg[cmd.ax] <= dir_zero ? vrt_pkg::LEN_NONE
                : vrt_pkg::LEN_W'(len_prod[vrt_pkg::FRAC_W+vrt_pkg::UNIT_W-1:16]);
        end

        // One walk step
        if (cmd.step) begin
            if (rdata != '0) begin
                blk_reg <= rdata;
                if (d_reg == '0) begin
                    mt_reg   <= vrt_pkg::MT_W'(1);
                    tneg_reg <= 1'b1;
                end else begin
                    mt_reg <= sat_mt(d_reg - 1'b1);
                end
            end else begin
                cell_reg[sel] <= cell_new;
                d_reg         <= d_new;
                len_reg[sel]  <= len_reg[sel] + vrt_pkg::LEN_W'(unit_reg[sel]);
                mt_reg        <= sat_mt(d_new);
            end
        end

        // Surface product in two partial products
        if (cmd.mul_lo) begin
            acc_reg <= vrt_pkg::ACC_W'(mt_reg[vrt_pkg::MT_LO_W-1:0] * mag_ax);
        end
        if (cmd.mul_hi) begin
            hi_reg <= vrt_pkg::ACC_W'(mt_reg[vrt_pkg::MT_W-1:vrt_pkg::MT_LO_W] * mag_ax);
        end
        if (cmd.surf_wr) begin
            surf_reg[cmd.ax] <= surf_val;
        end

        // Result register
        if (cmd.out_wr) begin
            out_reg <= {{PAD_W{1'b0}}, surf_reg[2], surf_reg[1], surf_reg[0],
                        cell_reg[2], cell_reg[1], cell_reg[0], blk_reg, dist_sat};
        end
    end

    assign m_tdata = out_reg;

    always_comb begin
        sts.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));
        sts.div_done  = div_done;
        sts.border    = border;
        sts.hit       = (rdata != '0);
        sts.exit_walk = (rdata == '0) && new_border;
    end

endmodule

// ===== rtl/vrt_ctrl.sv =====
// ---------------------------------------------------------------------------
// vrt_ctrl
// Controller: clearing pass, ray setup sequence, walk loop and result hand-off.
// ---------------------------------------------------------------------------
module vrt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_func,
    output logic          m_tvalid,
    input  logic          m_tready,
    output vrt_pkg::cmd_t cmd,
    input  vrt_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_LEN, ST_START,
        ST_READ, ST_CHECK, ST_MUL_LO, ST_MUL_HI, ST_SURF, ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] ax_reg, ax_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        ax_next       = ax_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.ax        = ax_reg;
        case (state_reg)
            // Zero every voxel once after reset
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_func == vrt_pkg::FUNC_CAST) begin
                        cmd.load   = 1'b1;
                        ax_next    = vrt_pkg::AX_X;
                        state_next = ST_DIV_GO;
                    end else begin
                        cmd.vox_wr = 1'b1;
                    end
                end
            end
            // Reciprocal and first boundary, axis by axis
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    cmd.unit_wr = 1'b1;
                    state_next  = ST_LEN;
                end
            end
            ST_LEN: begin
                cmd.len_wr = 1'b1;
                if (ax_reg == vrt_pkg::AX_Z) begin
                    state_next = ST_START;
                end else begin
                    ax_next    = ax_reg + 1'b1;
                    state_next = ST_DIV_GO;
                end
            end
            ST_START: begin
                ax_next    = vrt_pkg::AX_X;
                state_next = sts.border ? ST_MUL_LO : ST_READ;
            end
            // Walk: read the voxel, then step or stop
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.step = 1'b1;
                ax_next  = vrt_pkg::AX_X;
                if (sts.hit || sts.exit_walk) begin
                    state_next = ST_MUL_LO;
                end else begin
                    state_next = ST_READ;
                end
            end
            // Surface point per axis
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SURF;
            end
            ST_SURF: begin
                cmd.surf_wr = 1'b1;
                if (ax_reg == vrt_pkg::AX_Z) begin
                    state_next = ST_OUT;
                end else begin
                    ax_next    = ax_reg + 1'b1;
                    state_next = ST_MUL_LO;
                end
            end
            // Wait for the result register to free up
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_wr    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            ax_reg       <= vrt_pkg::AX_X;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ax_reg       <= ax_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== rtl/voxel_ray_traversal.sv =====
// ---------------------------------------------------------------------------
// voxel_ray_traversal
// 3D DDA ray walk over a voxel grid of block ids, with voxel writes.
// ---------------------------------------------------------------------------
// After reset a clearing pass over all GRID_X*GRID_Y*GRID_Z voxels zeroes the grid; no
//   item is taken meanwhile. aresetn is synchronous, active low.
// A write item inside the grid is stored as it is taken. A cast runs the divider and
//   writes the unit and first boundary length for each axis; each voxel walked costs one
//   RAM read and one step, the surface point two partial products and a write per axis.
//   One item is in work at a time; the result register lets the next item in while a result waits.
module voxel_ray_traversal #(
    parameter int unsigned GRID_X = vrt_pkg::GRID_X_DEF,
    parameter int unsigned GRID_Y = vrt_pkg::GRID_Y_DEF,
    parameter int unsigned GRID_Z = vrt_pkg::GRID_Z_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // voxel_x, voxel_y, voxel_z, block_value, start_x, start_y, start_z,
    // heading_x, heading_y, heading_z, zero pad
    input  logic [vrt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // distance, hit_block, cell_x, cell_y, cell_z, surface_x, surface_y, surface_z,
    // zero pad
    output logic [vrt_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    vrt_pkg::cmd_t cmd;
    vrt_pkg::sts_t sts;

    vrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    vrt_dpath #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

// ===== rtl/vrt_checker.sv =====
// ---------------------------------------------------------------------------
// vrt_checker
// Port-level checks of the voxel ray traversal, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vrt_checker #(
    parameter int unsigned GRID_X = vrt_pkg::GRID_X_DEF,
    parameter int unsigned GRID_Y = vrt_pkg::GRID_Y_DEF,
    parameter int unsigned GRID_Z = vrt_pkg::GRID_Z_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [0:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [vrt_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic [7:0] hit_id, cx, cy, cz;
    logic       on_border;

    assign hit_id = m_tdata[33:26];
    assign cx     = m_tdata[41:34];
    assign cy     = m_tdata[49:42];
    assign cz     = m_tdata[57:50];
    assign on_border = (cx == 8'd0) || (cx >= 8'(GRID_X)) || (cy == 8'd0)
                    || (cy >= 8'(GRID_Y)) || (cz == 8'd0) || (cz >= 8'(GRID_Z));

    // Grid is being cleared right after reset
    `VRT_ASSERT_RST(a_clear_after_reset, !aresetn |=> !s_tready, "item taken during clearing")
    // A cast occupies the block
    `VRT_ASSERT(a_cast_busy, s_tvalid && s_tready && s_tuser[0] |=> !s_tready, "busy cast took item")
    // An empty result always ends on the grid border
    `VRT_ASSERT(a_exit_border, m_tvalid && hit_id == 8'd0 |-> on_border, "exit off border")
    // Stalled result holds
    `VRT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result moved")

endmodule

bind voxel_ray_traversal vrt_checker #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
) u_vrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
